[sv/sfgp_pkg.sv]
// shared types, constants and queue entry layout for the stroke font glyph parser
`default_nettype none
package sfgp_pkg;

  localparam int unsigned MAX_VERTS  = 1023;
  localparam int unsigned VCNT_W     = $clog2(MAX_VERTS + 1);
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);

  localparam logic [7:0] CH_R        = 8'd82;
  localparam logic [7:0] CH_SP       = 8'd32;
  localparam logic [7:0] CH_NL       = 8'd10;
  localparam logic [7:0] CH_ZERO     = 8'd48;
  localparam logic [7:0] CH_NINE     = 8'd57;
  localparam logic [7:0] CODE_BASE   = 8'd32;
  localparam int unsigned DEC_RADIX  = 10;
  localparam int unsigned ID_COLS    = 5;
  localparam int unsigned COUNT_COLS = 3;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_PATH   = 2'd1,
    KIND_GLYPH  = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef struct packed {
    logic              first_valid;
    kind_t             first_kind;
    logic signed [7:0] vert_x;
    logic signed [6:0] vert_y;
    logic [9:0]        off1;
    logic [9:0]        size1;
    logic              fin;
    logic [9:0]        off2;
    logic [9:0]        size2;
    logic [6:0]        advance;
    logic [6:0]        height;
    logic signed [6:0] ymin;
    logic [7:0]        code;
    logic [6:0]        maxh;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t data;
  } q_wr_t;

  typedef struct packed {
    logic   valid;
    entry_t head;
  } q_rd_t;

endpackage
`default_nettype wire

[sv/sfgp_ifs.sv]
// byte and result channel interfaces of the stroke font glyph parser
`default_nettype none
interface sfgp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       line_start;
  logic       font_start;
  modport source(output valid, char_byte, line_start, font_start, input ready);
  modport sink(input valid, char_byte, line_start, font_start, output ready);
endinterface

interface sfgp_result_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic signed [7:0] vert_x;
  logic signed [6:0] vert_y;
  logic [9:0]        path_offset;
  logic [9:0]        path_size;
  logic [6:0]        advance;
  logic [6:0]        glyph_height;
  logic signed [6:0] glyph_ymin;
  logic [7:0]        glyph_code;
  logic [6:0]        max_height;
  logic              last;
  modport source(output valid, kind, vert_x, vert_y, path_offset, path_size, advance,
                 glyph_height, glyph_ymin, glyph_code, max_height, last, input ready);
  modport sink(input valid, kind, vert_x, vert_y, path_offset, path_size, advance,
               glyph_height, glyph_ymin, glyph_code, max_height, last, output ready);
endinterface
`default_nettype wire

[sv/sfgp_front.sv]
// front end: column parser that turns each byte into at most one queue entry of results
`default_nettype none
module sfgp_front (
  input  wire logic         clk,
  input  wire logic         rst,
  sfgp_byte_if.sink         bytes,
  input  wire logic         q_full,
  output sfgp_pkg::q_wr_t   q_wr
);

  typedef enum logic [2:0] {
    PH_WAIT, PH_ID, PH_COUNT, PH_LEFT, PH_RIGHT, PH_PAIR_A, PH_PAIR_B
  } phase_t;

  phase_t                              phase, phase_next;
  logic [2:0]                          col_idx, col_idx_next;
  logic [9:0]                          pairs_left, pairs_left_next;
  logic [7:0]                          left_extent, left_extent_next;
  logic [7:0]                          right_extent, right_extent_next;
  logic [7:0]                          held_first, held_first_next;
  logic [sfgp_pkg::VCNT_W-1:0]         path_begin, path_begin_next;
  logic [sfgp_pkg::VCNT_W-1:0]         vertex_count, vertex_count_next;
  logic signed [6:0]                   top_y, top_y_next;
  logic signed [6:0]                   bottom_y, bottom_y_next;
  logic                                any_vertex, any_vertex_next;
  logic [7:0]                          next_code, next_code_next;
  logic [6:0]                          tallest, tallest_next;

  sfgp_pkg::entry_t                    entry;
  logic                                in_fire;

  assign bytes.ready = !q_full;
  assign in_fire     = bytes.valid && bytes.ready;
  assign q_wr.push   = in_fire && (entry.first_valid || entry.fin);
  assign q_wr.data   = entry;

  always_comb begin
    logic              err;
    logic              finish;
    logic [13:0]       acc;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic [8:0]        da;
    logic signed [6:0] y;
    logic signed [7:0] dh;
    logic [6:0]        h;
    logic [7:0]        c;

    c                 = bytes.char_byte;
    err               = 1'b0;
    finish            = 1'b0;
    acc               = '0;
    dx                = '0;
    dy                = '0;
    da                = '0;
    y                 = '0;
    dh                = '0;
    h                 = '0;
    entry             = '0;
    phase_next        = phase;
    col_idx_next      = col_idx;
    pairs_left_next   = pairs_left;
    left_extent_next  = left_extent;
    right_extent_next = right_extent;
    held_first_next   = held_first;
    path_begin_next   = path_begin;
    vertex_count_next = vertex_count;
    top_y_next        = top_y;
    bottom_y_next     = bottom_y;
    any_vertex_next   = any_vertex;
    next_code_next    = next_code;
    tallest_next      = tallest;

    if (bytes.font_start) begin
      next_code_next = sfgp_pkg::CODE_BASE;
      tallest_next   = '0;
    end
    if (bytes.line_start) begin
      phase_next        = PH_ID;
      col_idx_next      = '0;
      pairs_left_next   = '0;
      left_extent_next  = '0;
      right_extent_next = '0;
      held_first_next   = '0;
      path_begin_next   = '0;
      vertex_count_next = '0;
      top_y_next        = '0;
      bottom_y_next     = '0;
      any_vertex_next   = 1'b0;
    end

    if (phase_next != PH_WAIT) begin
      if (c == sfgp_pkg::CH_NL) begin
        err = 1'b1;
      end else begin
        case (phase_next)
          PH_ID: begin
            if (col_idx_next == 3'(sfgp_pkg::ID_COLS - 1)) begin
              col_idx_next = '0;
              phase_next   = PH_COUNT;
            end else begin
              col_idx_next = col_idx_next + 3'd1;
            end
          end
          PH_COUNT: begin
            if (c >= sfgp_pkg::CH_ZERO && c <= sfgp_pkg::CH_NINE) begin
              acc = 14'(pairs_left_next) * 14'(sfgp_pkg::DEC_RADIX)
                    + 14'(c - sfgp_pkg::CH_ZERO);
              pairs_left_next = acc[9:0];
            end
            if (col_idx_next == 3'(sfgp_pkg::COUNT_COLS - 1)) begin
              col_idx_next = '0;
              if (pairs_left_next == '0) begin
                err = 1'b1;
              end else begin
                phase_next = PH_LEFT;
              end
            end else begin
              col_idx_next = col_idx_next + 3'd1;
            end
          end
          PH_LEFT: begin
            left_extent_next = c;
            phase_next       = PH_RIGHT;
          end
          PH_RIGHT: begin
            right_extent_next = c;
            if (c < left_extent_next) begin
              err = 1'b1;
            end else begin
              pairs_left_next = pairs_left_next - 10'd1;
              if (pairs_left_next == '0) begin
                finish = 1'b1;
              end else begin
                phase_next = PH_PAIR_A;
              end
            end
          end
          PH_PAIR_A: begin
            held_first_next = c;
            phase_next      = PH_PAIR_B;
          end
          PH_PAIR_B: begin
            if (held_first_next == sfgp_pkg::CH_SP && c == sfgp_pkg::CH_R) begin
              entry.first_valid = 1'b1;
              entry.first_kind  = sfgp_pkg::KIND_PATH;
              entry.off1        = 10'(path_begin_next);
              entry.size1       = 10'(vertex_count_next - path_begin_next);
              path_begin_next   = vertex_count_next;
            end else if (vertex_count_next < sfgp_pkg::VCNT_W'(sfgp_pkg::MAX_VERTS)) begin
              dx = $signed({1'b0, held_first_next}) - $signed({1'b0, left_extent_next});
              dy = $signed({1'b0, c}) - $signed({1'b0, sfgp_pkg::CH_R});
              if (dy > 9'sd63) begin
                y = 7'sd63;
              end else if (dy < -9'sd64) begin
                y = -7'sd64;
              end else begin
                y = dy[6:0];
              end
              if (dx > 9'sd127) begin
                entry.vert_x = 8'sd127;
              end else if (dx < -9'sd128) begin
                entry.vert_x = -8'sd128;
              end else begin
                entry.vert_x = dx[7:0];
              end
              entry.vert_y      = y;
              entry.first_valid = 1'b1;
              entry.first_kind  = sfgp_pkg::KIND_VERTEX;
              if (!any_vertex_next) begin
                top_y_next      = y;
                bottom_y_next   = y;
                any_vertex_next = 1'b1;
              end else begin
                if (y > top_y_next) top_y_next = y;
                if (y < bottom_y_next) bottom_y_next = y;
              end
              vertex_count_next = vertex_count_next + 1'b1;
            end
            pairs_left_next = pairs_left_next - 10'd1;
            if (pairs_left_next == '0) begin
              finish = 1'b1;
            end else begin
              phase_next = PH_PAIR_A;
            end
          end
          default: begin
            phase_next = PH_WAIT;
          end
        endcase
      end
    end

    if (err) begin
      entry             = '0;
      entry.first_valid = 1'b1;
      entry.first_kind  = sfgp_pkg::KIND_ERROR;
      phase_next        = PH_WAIT;
    end

    if (finish) begin
      da = {1'b0, right_extent_next} - {1'b0, left_extent_next};
      entry.advance = (da > 9'd127) ? 7'd127 : da[6:0];
      dh = 8'(top_y_next) - 8'(bottom_y_next);
      h  = any_vertex_next ? dh[6:0] : 7'd0;
      entry.height    = h;
      entry.ymin      = any_vertex_next ? bottom_y_next : 7'sd0;
      entry.fin       = 1'b1;
      entry.off2      = 10'(path_begin_next);
      entry.size2     = 10'(vertex_count_next - path_begin_next);
      path_begin_next = vertex_count_next;
      if (h > tallest_next) tallest_next = h;
      entry.maxh      = tallest_next;
      entry.code      = next_code_next;
      next_code_next  = next_code_next + 8'd1;
      phase_next      = PH_WAIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      col_idx      <= '0;
      pairs_left   <= '0;
      left_extent  <= '0;
      right_extent <= '0;
      held_first   <= '0;
      path_begin   <= '0;
      vertex_count <= '0;
      top_y        <= '0;
      bottom_y     <= '0;
      any_vertex   <= 1'b0;
      next_code    <= sfgp_pkg::CODE_BASE;
      tallest      <= '0;
    end else if (in_fire) begin
      phase        <= phase_next;
      col_idx      <= col_idx_next;
      pairs_left   <= pairs_left_next;
      left_extent  <= left_extent_next;
      right_extent <= right_extent_next;
      held_first   <= held_first_next;
      path_begin   <= path_begin_next;
      vertex_count <= vertex_count_next;
      top_y        <= top_y_next;
      bottom_y     <= bottom_y_next;
      any_vertex   <= any_vertex_next;
      next_code    <= next_code_next;
      tallest      <= tallest_next;
    end
  end

endmodule
`default_nettype wire

[sv/sfgp_queue.sv]
// short entry queue between the parser front end and the result back end
`default_nettype none
module sfgp_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sfgp_pkg::q_wr_t  q_wr,
  output logic                  q_full,
  input  wire logic             pop,
  output sfgp_pkg::q_rd_t       q_rd
);

  sfgp_pkg::entry_t              slots [sfgp_pkg::QDEPTH];
  logic [sfgp_pkg::QPTR_W-1:0]   wr_ptr;
  logic [sfgp_pkg::QPTR_W-1:0]   rd_ptr;
  logic [sfgp_pkg::QPTR_W:0]     count;
  logic                          do_push;
  logic                          do_pop;

  assign q_full     = (count == (sfgp_pkg::QPTR_W + 1)'(sfgp_pkg::QDEPTH));
  assign q_rd.valid = (count != '0);
  assign q_rd.head  = slots[rd_ptr];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= q_wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/sfgp_back.sv]
// back end: expands each queue entry into one to three result words
`default_nettype none
module sfgp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sfgp_pkg::q_rd_t  q_rd,
  output logic                  pop,
  sfgp_result_if.source         results
);

  typedef enum logic [1:0] {ST_FIRST, ST_PATH, ST_GLYPH} step_t;

  step_t step, step_next, eff;
  logic  done;
  logic  out_fire;

  assign eff      = (step == ST_FIRST && !q_rd.head.first_valid) ? ST_PATH : step;
  assign done     = (eff == ST_GLYPH) || (eff == ST_FIRST && !q_rd.head.fin);
  assign out_fire = results.valid && results.ready;
  assign pop      = out_fire && done;

  always_comb begin
    results.valid        = q_rd.valid;
    results.kind         = sfgp_pkg::KIND_VERTEX;
    results.vert_x       = '0;
    results.vert_y       = '0;
    results.path_offset  = '0;
    results.path_size    = '0;
    results.advance      = '0;
    results.glyph_height = '0;
    results.glyph_ymin   = '0;
    results.glyph_code   = '0;
    results.max_height   = '0;
    results.last         = 1'b0;
    case (eff)
      ST_FIRST: begin
        results.kind = q_rd.head.first_kind;
        case (q_rd.head.first_kind)
          sfgp_pkg::KIND_VERTEX: begin
            results.vert_x = q_rd.head.vert_x;
            results.vert_y = q_rd.head.vert_y;
          end
          sfgp_pkg::KIND_PATH: begin
            results.path_offset = q_rd.head.off1;
            results.path_size   = q_rd.head.size1;
          end
          sfgp_pkg::KIND_ERROR: results.last = 1'b1;
          default: results.last = 1'b0;
        endcase
      end
      ST_PATH: begin
        results.kind        = sfgp_pkg::KIND_PATH;
        results.path_offset = q_rd.head.off2;
        results.path_size   = q_rd.head.size2;
      end
      ST_GLYPH: begin
        results.kind         = sfgp_pkg::KIND_GLYPH;
        results.advance      = q_rd.head.advance;
        results.glyph_height = q_rd.head.height;
        results.glyph_ymin   = q_rd.head.ymin;
        results.glyph_code   = q_rd.head.code;
        results.max_height   = q_rd.head.maxh;
        results.last         = 1'b1;
      end
      default: results.kind = sfgp_pkg::KIND_VERTEX;
    endcase
  end

  always_comb begin
    step_next = step;
    if (out_fire) begin
      if (done) begin
        step_next = ST_FIRST;
      end else if (eff == ST_FIRST) begin
        step_next = ST_PATH;
      end else begin
        step_next = ST_GLYPH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_FIRST;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

[sv/stroke_font_glyph_parser.sv]
// top level of the stroke font glyph parser: front end, entry queue, back end
// The block takes one text byte per cycle as long as its four-entry queue has room, and
// each byte produces zero to three result words: a vertex, path end or error word, and at
// the end of a line the closing path end and the glyph summary. The back end sends one
// result word per cycle while the output is ready, so a byte that closes a glyph right
// after a vertex occupies the output for three result words; the queue lets the byte side
// keep going meanwhile, and a line settles to one byte per cycle wherever the output keeps
// up. Up to MAX_VERTS vertices per glyph are counted; further vertices are dropped.
`default_nettype none
module stroke_font_glyph_parser (
  input  wire logic      clk,
  input  wire logic      rst,
  sfgp_byte_if.sink      bytes,
  sfgp_result_if.source  results
);

  sfgp_pkg::q_wr_t q_wr;
  sfgp_pkg::q_rd_t q_rd;
  logic            q_full;
  logic            pop;

  sfgp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  sfgp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .q_full (q_full),
    .pop    (pop),
    .q_rd   (q_rd)
  );

  sfgp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_rd    (q_rd),
    .pop     (pop),
    .results (results)
  );

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.kind == sfgp_pkg::KIND_ERROR |-> results.last)
    else $error("error word without last");

  a_glyph_last: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.kind == sfgp_pkg::KIND_GLYPH |-> results.last)
    else $error("glyph word without last");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_wr.push |-> !q_full)
    else $error("queue written while full");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_rd.valid && results.ready)
    else $error("queue popped without a taken word");

endmodule
`default_nettype wire
